/* sv/sorted_table_binary_search_core_assert.svh */
// ----------------------------------------------------------------------------
// Sorted table binary search core - assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define STBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define STBS_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define STBS_ASSERT(lbl, clk, rst, prop, msg)

`define STBS_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

/* sv/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search - shared package
// Field widths, item modes, search phases, result selects and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int MODE_W     = 3;
   localparam int INDEX_W    = 10;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 11;
   localparam int LEN_W      = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_TABLE_LENGTH   = 1'b0;
   localparam logic CSR_IDX_COMPARE_SIGNED = 1'b1;

   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 3'd0,
      MODE_FIND  = 3'd1,
      MODE_LOWER = 3'd2,
      MODE_UPPER = 3'd3,
      MODE_EQUAL = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_FIND,
      PHASE_LOWER,
      PHASE_UPPER
   } phase_type;

   typedef enum logic [1:0] {
      RSEL_MISS,
      RSEL_MID,
      RSEL_LOW,
      RSEL_RANGE
   } rsel_type;

   typedef struct packed {
      logic      wr_en;
      logic      load_query;
      logic      issue_read;
      logic      step;
      logic      save_hit;
      logic      start_upper;
      logic      rsp_load;
      phase_type phase;
      rsel_type  rsel;
   } cmd_type;

   typedef struct packed {
      logic range_empty;
      logic cmp_lt;
      logic cmp_eq;
   } status_type;

endpackage

/* sv/sorted_table_binary_search_core.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search core - top level
// A write item is taken while idle. A query item runs a probe read and a
// compare for each halving step, set by the table memory's registered read
// port (the probe reads the entry at mid, the compare narrows the bounds),
// then loads the result once the output is free to hand it off. An equal
// range query that hits runs the match pass and then a lower and an upper
// bound pass over the two halves. A new item is taken while the previous
// result still waits on the output.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [stbs_pkg::MODE_W-1:0]       req_mode,
   input  logic [stbs_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [stbs_pkg::VALUE_W-1:0]      req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [stbs_pkg::POS_W-1:0]        rsp_position,
   output logic [stbs_pkg::POS_W-1:0]        rsp_range_end,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [stbs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   stbs_pkg::cmd_type    cmd;
   stbs_pkg::status_type status;
   stbs_pkg::len_type    table_length;
   logic                 compare_signed;

   stbs_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .table_length   (table_length),
      .compare_signed (compare_signed)
   );

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stbs_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .table_length    (table_length),
      .compare_signed  (compare_signed),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_range_end   (rsp_range_end)
   );

endmodule

/* sv/stbs_csr.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search - configuration registers
// APB-style register file holding the searched length and the compare order.
// ----------------------------------------------------------------------------
module stbs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  stbs_pkg::csr_data_type       csr_pwdata,
   output stbs_pkg::csr_data_type       csr_prdata,
   output logic                         csr_pready,
   output stbs_pkg::len_type            table_length,
   output logic                         compare_signed
);

   stbs_pkg::len_type table_length_ff;
   logic              compare_signed_ff;
   logic              wr_stb;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff   <= '0;
         compare_signed_ff <= 1'b0;
      end else if (wr_stb) begin
         case (reg_sel)
            stbs_pkg::CSR_IDX_TABLE_LENGTH: begin
               table_length_ff <= csr_pwdata[stbs_pkg::LEN_W-1:0];
            end
            stbs_pkg::CSR_IDX_COMPARE_SIGNED: begin
               compare_signed_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         stbs_pkg::CSR_IDX_TABLE_LENGTH: begin
            csr_prdata = stbs_pkg::csr_data_type'(table_length_ff);
         end
         stbs_pkg::CSR_IDX_COMPARE_SIGNED: begin
            csr_prdata = stbs_pkg::csr_data_type'(compare_signed_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign table_length   = table_length_ff;
   assign compare_signed = compare_signed_ff;

endmodule

/* sv/stbs_dpath.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search - datapath
// Table memory, search bounds, probe compare and result registers.
// ----------------------------------------------------------------------------
module stbs_dpath #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                            clock,
   input  stbs_pkg::cmd_type               cmd,
   output stbs_pkg::status_type            status,
   input  logic [stbs_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [stbs_pkg::VALUE_W-1:0]    req_value,
   input  stbs_pkg::len_type               table_length,
   input  logic                            compare_signed,
   output logic                            rsp_found,
   output stbs_pkg::pos_type               rsp_position,
   output stbs_pkg::pos_type               rsp_range_end
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [ENTRY_WIDTH-1:0] SIGN_BIT = ENTRY_WIDTH'(1) << (ENTRY_WIDTH - 1);

   logic [ENTRY_WIDTH-1:0] table_ff [TABLE_DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;
   logic [ENTRY_WIDTH-1:0] key_ff;
   logic [CNT_W-1:0]       low_ff, low_in;
   logic [CNT_W-1:0]       high_ff, high_in;
   logic [CNT_W-1:0]       mid_ff;
   logic [CNT_W-1:0]       hmid_ff;
   logic [CNT_W-1:0]       shigh_ff;
   logic [CNT_W-1:0]       lpos_ff;
   logic                   rsp_found_ff;
   stbs_pkg::pos_type      rsp_position_ff;
   stbs_pkg::pos_type      rsp_range_end_ff;

   logic [ENTRY_WIDTH-1:0] flip;
   logic [ENTRY_WIDTH-1:0] entry_w;
   logic [ENTRY_WIDTH-1:0] probe_key;
   logic [CNT_W-1:0]       len_w;
   logic [CNT_W-1:0]       span_w;
   logic [CNT_W-1:0]       mid_w;
   logic [CNT_W-1:0]       mid_next;
   logic                   wr_ok;
   logic [IDX_W-1:0]       wr_addr;

   assign flip      = compare_signed ? SIGN_BIT : '0;
   assign entry_w   = ENTRY_WIDTH'(req_value);
   assign probe_key = rd_data_ff ^ flip;
   assign len_w     = (32'(table_length) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(table_length);
   assign span_w    = high_ff - low_ff;
   assign mid_w     = low_ff + (span_w >> 1);
   assign mid_next  = mid_ff + CNT_W'(1);
   assign wr_ok     = cmd.wr_en && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign wr_addr   = IDX_W'(req_entry_index);

   assign status.range_empty = !(low_ff < high_ff);
   assign status.cmp_lt      = probe_key < key_ff;
   assign status.cmp_eq      = probe_key == key_ff;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.load_query) begin
         low_in  = '0;
         high_in = len_w;
      end
      if (cmd.step) begin
         case (cmd.phase)
            stbs_pkg::PHASE_FIND: begin
               if (status.cmp_lt) begin
                  low_in = mid_next;
               end else if (!status.cmp_eq) begin
                  high_in = mid_ff;
               end
            end
            stbs_pkg::PHASE_LOWER: begin
               if (status.cmp_lt) begin
                  low_in = mid_next;
               end else begin
                  high_in = mid_ff;
               end
            end
            stbs_pkg::PHASE_UPPER: begin
               if (status.cmp_lt || status.cmp_eq) begin
                  low_in = mid_next;
               end else begin
                  high_in = mid_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.save_hit) begin
         high_in = mid_ff;
      end
      if (cmd.start_upper) begin
         low_in  = hmid_ff;
         high_in = shigh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         table_ff[wr_addr] <= entry_w;
      end
      if (cmd.issue_read) begin
         mid_ff     <= mid_w;
         rd_data_ff <= table_ff[mid_w[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      if (cmd.load_query) begin
         key_ff <= entry_w ^ flip;
      end
      if (cmd.save_hit) begin
         hmid_ff  <= mid_ff;
         shigh_ff <= high_ff;
      end
      if (cmd.start_upper) begin
         lpos_ff <= low_ff;
      end
      if (cmd.rsp_load) begin
         case (cmd.rsel)
            stbs_pkg::RSEL_MISS: begin
               rsp_found_ff     <= 1'b0;
               rsp_position_ff  <= '0;
               rsp_range_end_ff <= '0;
            end
            stbs_pkg::RSEL_MID: begin
               rsp_found_ff     <= 1'b1;
               rsp_position_ff  <= stbs_pkg::pos_type'(mid_ff);
               rsp_range_end_ff <= stbs_pkg::pos_type'(mid_ff);
            end
            stbs_pkg::RSEL_RANGE: begin
               rsp_found_ff     <= 1'b1;
               rsp_position_ff  <= stbs_pkg::pos_type'(lpos_ff);
               rsp_range_end_ff <= stbs_pkg::pos_type'(low_ff);
            end
            default: begin
               rsp_found_ff     <= 1'b1;
               rsp_position_ff  <= stbs_pkg::pos_type'(low_ff);
               rsp_range_end_ff <= stbs_pkg::pos_type'(low_ff);
            end
         endcase
      end
   end

   assign rsp_found     = rsp_found_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_range_end = rsp_range_end_ff;

endmodule

/* sv/stbs_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search - controller
// Sequences writes, probe read and compare steps, the equal range passes and
// the result handoff.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_core_assert.svh"

module stbs_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [stbs_pkg::MODE_W-1:0]     req_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  stbs_pkg::status_type            status,
   output stbs_pkg::cmd_type               cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE
   } state_type;

   state_type           state_ff;
   stbs_pkg::mode_type  mode_ff;
   stbs_pkg::phase_type phase_ff;
   logic                rsp_valid_ff;

   stbs_pkg::mode_type  req_mode_w;
   logic                out_free;

   assign req_mode_w = stbs_pkg::mode_type'(req_mode);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      cmd.phase = phase_ff;
      cmd.rsel  = stbs_pkg::RSEL_MISS;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode_w)
                  stbs_pkg::MODE_WRITE: begin
                     cmd.wr_en = 1'b1;
                  end
                  stbs_pkg::MODE_FIND, stbs_pkg::MODE_LOWER,
                  stbs_pkg::MODE_UPPER, stbs_pkg::MODE_EQUAL: begin
                     cmd.load_query = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (!status.range_empty) begin
               cmd.issue_read = 1'b1;
            end else begin
               case (phase_ff)
                  stbs_pkg::PHASE_FIND: begin
                     if (mode_ff == stbs_pkg::MODE_FIND) begin
                        cmd.rsel = stbs_pkg::RSEL_MISS;
                     end else begin
                        cmd.rsel = stbs_pkg::RSEL_LOW;
                     end
                     cmd.rsp_load = out_free;
                  end
                  stbs_pkg::PHASE_LOWER: begin
                     if (mode_ff == stbs_pkg::MODE_EQUAL) begin
                        cmd.start_upper = 1'b1;
                     end else begin
                        cmd.rsel     = stbs_pkg::RSEL_LOW;
                        cmd.rsp_load = out_free;
                     end
                  end
                  stbs_pkg::PHASE_UPPER: begin
                     if (mode_ff == stbs_pkg::MODE_EQUAL) begin
                        cmd.rsel = stbs_pkg::RSEL_RANGE;
                     end else begin
                        cmd.rsel = stbs_pkg::RSEL_LOW;
                     end
                     cmd.rsp_load = out_free;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COMPARE: begin
            if (phase_ff == stbs_pkg::PHASE_FIND && status.cmp_eq) begin
               if (mode_ff == stbs_pkg::MODE_FIND) begin
                  cmd.rsel     = stbs_pkg::RSEL_MID;
                  cmd.rsp_load = out_free;
               end else begin
                  cmd.save_hit = 1'b1;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= stbs_pkg::MODE_WRITE;
         phase_ff     <= stbs_pkg::PHASE_FIND;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.load_query) begin
                  state_ff <= ST_PROBE;
                  mode_ff  <= req_mode_w;
                  case (req_mode_w)
                     stbs_pkg::MODE_LOWER: begin
                        phase_ff <= stbs_pkg::PHASE_LOWER;
                     end
                     stbs_pkg::MODE_UPPER: begin
                        phase_ff <= stbs_pkg::PHASE_UPPER;
                     end
                     default: begin
                        phase_ff <= stbs_pkg::PHASE_FIND;
                     end
                  endcase
               end
            end
            ST_PROBE: begin
               if (cmd.issue_read) begin
                  state_ff <= ST_COMPARE;
               end else if (cmd.start_upper) begin
                  phase_ff <= stbs_pkg::PHASE_UPPER;
               end else if (cmd.rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_COMPARE: begin
               if (cmd.save_hit) begin
                  phase_ff <= stbs_pkg::PHASE_LOWER;
                  state_ff <= ST_PROBE;
               end else if (cmd.step) begin
                  state_ff <= ST_PROBE;
               end else if (cmd.rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `STBS_ASSERT(a_cmd_onehot, clock, reset,
      $onehot0({cmd.wr_en, cmd.load_query, cmd.issue_read, cmd.step, cmd.save_hit,
                cmd.start_upper, cmd.rsp_load}),
      "more than one datapath command at once")
   `STBS_ASSERT(a_compare_after_probe, clock, reset,
      (state_ff == ST_COMPARE) |-> ($past(state_ff) != ST_IDLE),
      "compare without a preceding probe read")
   `STBS_NEVER(a_find_phase_mode, clock, reset,
      (state_ff != ST_IDLE) && (phase_ff == stbs_pkg::PHASE_FIND) &&
      !(mode_ff == stbs_pkg::MODE_FIND || mode_ff == stbs_pkg::MODE_EQUAL),
      "match pass running for a bound query")
   `STBS_ASSERT(a_result_ends_item, clock, reset,
      cmd.rsp_load |=> (rsp_valid_ff && state_ff == ST_IDLE),
      "result loaded but item not retired")

endmodule
